[rtl/sclru_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sclru_pkg;

  // Store geometry.
  localparam int SET_COUNT = 16384;
  localparam int SET_IDX_W = $clog2(SET_COUNT);

  // Field widths of a request.
  localparam int SET_FIELD_W = 14;
  localparam int WAY_W       = 3;

  // Data cache: ways and counter width.
  localparam int DATA_WAYS = 8;
  localparam int DATA_BITS = 3;
  localparam int DATA_W    = DATA_WAYS * DATA_BITS;
  localparam int DWAY_IW   = $clog2(DATA_WAYS);

  // Instruction cache: ways and counter width.
  localparam int INST_WAYS = 4;
  localparam int INST_BITS = 2;
  localparam int INST_W    = INST_WAYS * INST_BITS;
  localparam int IWAY_IW   = $clog2(INST_WAYS);

  // Packed counters on the result.
  localparam int OUT_W = 24;

  // Cache select codes.
  localparam logic FUNC_DATA = 1'b0;
  localparam logic FUNC_INST = 1'b1;

  typedef struct packed {
    logic                   func;
    logic [SET_FIELD_W-1:0] set_index;
    logic [WAY_W-1:0]       way;
    logic                   fill_empty;
  } in_req_t;

  typedef struct packed {
    logic [OUT_W-1:0] set_counters;
    logic             bad_way;
  } out_rsp_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC
  } state_t;

endpackage

`default_nettype wire

[rtl/sclru_age_calc.sv]
`timescale 1ns / 1ps
`default_nettype none

module sclru_age_calc (
  input  wire logic                        func,
  input  wire logic [sclru_pkg::WAY_W-1:0] way,
  input  wire logic                        fill,
  input  wire logic [sclru_pkg::DATA_W-1:0] word_d,
  input  wire logic [sclru_pkg::INST_W-1:0] word_i,
  output logic      [sclru_pkg::DATA_W-1:0] new_d,
  output logic      [sclru_pkg::INST_W-1:0] new_i,
  output logic      [sclru_pkg::OUT_W-1:0]  set_counters,
  output logic                              bad
);

  logic [sclru_pkg::DATA_BITS-1:0] d_acc;
  logic [sclru_pkg::INST_BITS-1:0] i_acc;
  logic [sclru_pkg::DWAY_IW-1:0]   d_idx;
  logic [sclru_pkg::IWAY_IW-1:0]   i_idx;

  assign d_idx = way[sclru_pkg::DWAY_IW-1:0];
  assign i_idx = way[sclru_pkg::IWAY_IW-1:0];

  // Original counter of the accessed way; the compares without fill use it.
  assign d_acc = word_d[sclru_pkg::DATA_BITS * int'(d_idx) +: sclru_pkg::DATA_BITS];
  assign i_acc = word_i[sclru_pkg::INST_BITS * int'(i_idx) +: sclru_pkg::INST_BITS];

  // Data cache ages: decrement the chosen ways, then mark the accessed way newest.
  always_comb begin
    logic [sclru_pkg::DATA_BITS-1:0] c;
    logic                            dec;
    new_d = '0;
    for (int i = 0; i < sclru_pkg::DATA_WAYS; i++) begin
      c   = word_d[sclru_pkg::DATA_BITS * i +: sclru_pkg::DATA_BITS];
      dec = fill ? (sclru_pkg::WAY_W'(i) < way) : (c >= d_acc);
      if (dec) begin
        c = c - 1'b1;
      end
      if (sclru_pkg::WAY_W'(i) == way) begin
        c = '1;
      end
      new_d[sclru_pkg::DATA_BITS * i +: sclru_pkg::DATA_BITS] = c;
    end
  end

  // Instruction cache ages, same rule with narrower counters.
  always_comb begin
    logic [sclru_pkg::INST_BITS-1:0] c;
    logic                            dec;
    new_i = '0;
    for (int i = 0; i < sclru_pkg::INST_WAYS; i++) begin
      c   = word_i[sclru_pkg::INST_BITS * i +: sclru_pkg::INST_BITS];
      dec = fill ? (sclru_pkg::WAY_W'(i) < way) : (c >= i_acc);
      if (dec) begin
        c = c - 1'b1;
      end
      if (sclru_pkg::WAY_W'(i) == way) begin
        c = '1;
      end
      new_i[sclru_pkg::INST_BITS * i +: sclru_pkg::INST_BITS] = c;
    end
  end

  // A way beyond the selected cache leaves the set unchanged.
  always_comb begin
    if (func == sclru_pkg::FUNC_INST) begin
      bad = ({1'b0, way} >= (sclru_pkg::WAY_W + 1)'(sclru_pkg::INST_WAYS));
      set_counters = bad ? sclru_pkg::OUT_W'(word_i) : sclru_pkg::OUT_W'(new_i);
    end else begin
      bad = ({1'b0, way} >= (sclru_pkg::WAY_W + 1)'(sclru_pkg::DATA_WAYS));
      set_counters = bad ? sclru_pkg::OUT_W'(word_d) : sclru_pkg::OUT_W'(new_d);
    end
  end

endmodule

`default_nettype wire

[rtl/split_cache_lru_counter_update.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake           Payload
// in_       input      in_valid/in_stall   in_req  (func, set_index, way, fill_empty)
// out_      output     out_valid/out_stall out_rsp (set_counters, bad_way)
//
// Each request is read from the age stores as it is taken, then updated in
// ST_CALC, written back and loaded into the output register.
// After reset a clearing pass writes zero to all 16384 sets, one set per cycle,
// and in_stall stays high for that time.
// A result waiting in the output register holds the update cycle only when the
// next result is ready before the waiting one is taken.

module split_cache_lru_counter_update (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire sclru_pkg::in_req_t  in_req,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output sclru_pkg::out_rsp_t      out_rsp
);

  // Age stores: one word per set.
  logic [sclru_pkg::DATA_W-1:0] d_mem [sclru_pkg::SET_COUNT];
  logic [sclru_pkg::INST_W-1:0] i_mem [sclru_pkg::SET_COUNT];

  sclru_pkg::state_t            state_r, state_nxt;
  logic [sclru_pkg::SET_IDX_W-1:0] clr_cnt_r, clr_cnt_nxt;
  sclru_pkg::in_req_t           req_r;
  logic                         out_valid_r, out_valid_nxt;
  sclru_pkg::out_rsp_t          out_rsp_r, out_rsp_nxt;

  logic [sclru_pkg::DATA_W-1:0] d_rd_r;
  logic [sclru_pkg::INST_W-1:0] i_rd_r;

  logic                         in_acc;
  logic                         out_free;
  logic                         d_we, i_we;
  logic [sclru_pkg::SET_IDX_W-1:0] wr_addr;
  logic [sclru_pkg::DATA_W-1:0] d_wdata;
  logic [sclru_pkg::INST_W-1:0] i_wdata;

  logic [sclru_pkg::DATA_W-1:0] new_d;
  logic [sclru_pkg::INST_W-1:0] new_i;
  logic [sclru_pkg::OUT_W-1:0]  calc_counters;
  logic                         calc_bad;

  assign in_stall  = (state_r != sclru_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // Update of the set that was read.
  sclru_age_calc u_calc (
    .func         (req_r.func),
    .way          (req_r.way),
    .fill         (req_r.fill_empty),
    .word_d       (d_rd_r),
    .word_i       (i_rd_r),
    .new_d        (new_d),
    .new_i        (new_i),
    .set_counters (calc_counters),
    .bad          (calc_bad)
  );

  // Sequencer: clearing pass, then read and update one request at a time.
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_rsp_nxt   = out_rsp_r;
    d_we          = 1'b0;
    i_we          = 1'b0;
    wr_addr       = req_r.set_index[sclru_pkg::SET_IDX_W-1:0];
    d_wdata       = new_d;
    i_wdata       = new_i;
    unique case (state_r)
      sclru_pkg::ST_CLEAR: begin
        d_we        = 1'b1;
        i_we        = 1'b1;
        wr_addr     = clr_cnt_r;
        d_wdata     = '0;
        i_wdata     = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == sclru_pkg::SET_IDX_W'(sclru_pkg::SET_COUNT - 1)) begin
          state_nxt = sclru_pkg::ST_IDLE;
        end
      end
      sclru_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = sclru_pkg::ST_CALC;
        end
      end
      sclru_pkg::ST_CALC: begin
        if (out_free) begin
          d_we          = !calc_bad && (req_r.func == sclru_pkg::FUNC_DATA);
          i_we          = !calc_bad && (req_r.func == sclru_pkg::FUNC_INST);
          out_valid_nxt = 1'b1;
          out_rsp_nxt.set_counters = calc_counters;
          out_rsp_nxt.bad_way      = calc_bad;
          state_nxt     = sclru_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sclru_pkg::ST_CLEAR;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sclru_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    out_rsp_r <= out_rsp_nxt;
    if (in_acc) begin
      req_r <= in_req;
    end
  end

  // Store writes.
  always_ff @(posedge clk) begin
    if (d_we) begin
      d_mem[wr_addr] <= d_wdata;
    end
    if (i_we) begin
      i_mem[wr_addr] <= i_wdata;
    end
  end

  // Store reads, issued as a request is taken.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      d_rd_r <= d_mem[in_req.set_index[sclru_pkg::SET_IDX_W-1:0]];
      i_rd_r <= i_mem[in_req.set_index[sclru_pkg::SET_IDX_W-1:0]];
    end
  end

`ifndef SYNTHESIS
  // A taken request puts the sequencer into ST_CALC in the following cycle.
  a_acc_to_calc: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == sclru_pkg::ST_CALC))
    else $error("request not followed by update cycle");

  // Both stores are written together only by the clearing pass.
  a_dual_write: assert property (@(posedge clk) disable iff (!rst_n)
    (d_we && i_we) |-> (state_r == sclru_pkg::ST_CLEAR))
    else $error("both stores written outside clearing pass");

  // A flagged way never changes a store.
  a_bad_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == sclru_pkg::ST_CALC) && calc_bad) |-> (!d_we && !i_we))
    else $error("store written for a bad way");

  // A result is loaded only when the previous one has gone or is leaving.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == sclru_pkg::ST_CALC) && out_valid_r && out_stall) |=>
      (state_r == sclru_pkg::ST_CALC))
    else $error("update completed while output was stalled");
`endif

endmodule

`default_nettype wire

[tb/sv/split_cache_lru_counter_update_tb.sv]
`timescale 1ns / 1ps

module split_cache_lru_counter_update_tb;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int ITEMS_PER_PHASE = 430;
  localparam int SQUEEZE_CYCLES  = 80;
  localparam int DRAIN_CYCLES    = 10;
  localparam int PRINT_LIMIT     = 100;

  // One row of the directed table: a request and, where it is obvious, its result.
  typedef struct {
    sclru_pkg::in_req_t  req;
    bit                  known;
    sclru_pkg::out_rsp_t want;
  } access_row_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  sclru_pkg::in_req_t  in_req    = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  sclru_pkg::out_rsp_t out_rsp;

  // Predictor state: age counters of both caches, cleared as after reset.
  logic [sclru_pkg::DATA_W-1:0] data_ages [sclru_pkg::SET_COUNT];
  logic [sclru_pkg::INST_W-1:0] inst_ages [sclru_pkg::SET_COUNT];

  sclru_pkg::out_rsp_t pending_counters [$];
  access_row_t         access_table [$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int send_idle_pct  = 24;
  int recv_idle_pct  = 83;
  int squeeze_asked  = 0;
  int squeeze_taken  = 0;
  int squeeze_left   = 0;
  sclru_pkg::out_rsp_t seen_rsp;

  split_cache_lru_counter_update uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp)
  );

  always #1 clk = ~clk;

  // Prints one line per mismatch, up to a limit, and counts them all.
  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("%0t: mismatch on %s: got %h, expected %h", $realtime, field, got, want);
    end
    mismatch_count++;
  endtask

  // Applies one cache access to the predicted counters and returns the result.
  function automatic sclru_pkg::out_rsp_t predict_access(input sclru_pkg::in_req_t r);
    sclru_pkg::out_rsp_t res;
    logic [23:0] word;
    logic [23:0] upd;
    int unsigned ways;
    int unsigned bits;
    int unsigned cmax;
    int unsigned acc;
    int unsigned c;
    int unsigned i;
    if (r.func == sclru_pkg::FUNC_DATA) begin
      word = data_ages[r.set_index];
      ways = sclru_pkg::DATA_WAYS;
      bits = sclru_pkg::DATA_BITS;
    end else begin
      word = 24'(inst_ages[r.set_index]);
      ways = sclru_pkg::INST_WAYS;
      bits = sclru_pkg::INST_BITS;
    end
    cmax = (1 << bits) - 1;
    res.bad_way = (r.way >= ways);
    res.set_counters = word;
    if (!res.bad_way) begin
      // Without fill, compare against the original counters; the accessed way ends at all ones.
      acc = (word >> (bits * r.way)) & cmax;
      upd = '0;
      for (i = 0; i < ways; i++) begin
        c = (word >> (bits * i)) & cmax;
        if (r.fill_empty ? (i < r.way) : (c >= acc)) begin
          c = (c - 1) & cmax;
        end
        if (i == r.way) begin
          c = cmax;
        end
        upd = upd | 24'(c << (bits * i));
      end
      if (r.func == sclru_pkg::FUNC_DATA) begin
        data_ages[r.set_index] = upd;
      end else begin
        inst_ages[r.set_index] = upd[sclru_pkg::INST_W-1:0];
      end
      res.set_counters = upd;
    end
    return res;
  endfunction

  function automatic void add_row(input logic func, input int set_idx, input int way,
                                  input bit fill, input bit known,
                                  input logic [23:0] counters, input bit bad);
    access_row_t row;
    row.req.func = func;
    row.req.set_index = set_idx[sclru_pkg::SET_FIELD_W-1:0];
    row.req.way = way[sclru_pkg::WAY_W-1:0];
    row.req.fill_empty = fill;
    row.known = known;
    row.want.set_counters = counters;
    row.want.bad_way = bad;
    access_table.push_back(row);
  endfunction

  // Random accesses crowd onto a few sets so that their counters age deeply.
  function automatic sclru_pkg::in_req_t make_random_access();
    sclru_pkg::in_req_t r;
    int unsigned        pick;
    r.func = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 80) begin
      r.set_index = sclru_pkg::SET_FIELD_W'($urandom_range(7));
    end else if (pick < 90) begin
      r.set_index = sclru_pkg::SET_FIELD_W'(sclru_pkg::SET_COUNT - 1 -
                                            int'($urandom_range(3)));
    end else begin
      r.set_index = sclru_pkg::SET_FIELD_W'($urandom_range(sclru_pkg::SET_COUNT - 1));
    end
    if (r.func == sclru_pkg::FUNC_INST && $urandom_range(99) < 85) begin
      r.way = sclru_pkg::WAY_W'($urandom_range(sclru_pkg::INST_WAYS - 1));
    end else begin
      r.way = sclru_pkg::WAY_W'($urandom_range(7));
    end
    r.fill_empty = ($urandom_range(99) < 25);
    return r;
  endfunction

  // Offers one request, after a random gap, and records its result once accepted.
  task automatic send_access(input sclru_pkg::in_req_t r, input bit known,
                             input sclru_pkg::out_rsp_t want);
    sclru_pkg::out_rsp_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= r;
    do begin
      @(posedge clk);
    end while (in_stall !== 1'b0);
    predicted = predict_access(r);
    pending_counters.push_back(known ? want : predicted);
  endtask

  // Receiver: random stalls, plus a long hold-off whenever one is asked for.
  always @(posedge clk) begin
    if (squeeze_left != 0) begin
      out_stall <= 1'b1;
      squeeze_left <= squeeze_left - 1;
    end else if (squeeze_taken != squeeze_asked) begin
      squeeze_taken <= squeeze_asked;
      squeeze_left <= SQUEEZE_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Checks each accepted result against the oldest expected one.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_counters.size() == 0) begin
        report_mismatch("unexpected result", 32'(out_rsp.set_counters), '0);
      end else begin
        seen_rsp = pending_counters.pop_front();
        if (out_rsp.set_counters !== seen_rsp.set_counters) begin
          report_mismatch("set_counters", 32'(out_rsp.set_counters),
                          32'(seen_rsp.set_counters));
        end
        if (out_rsp.bad_way !== seen_rsp.bad_way) begin
          report_mismatch("bad_way", 32'(out_rsp.bad_way), 32'(seen_rsp.bad_way));
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("split_cache_lru_counter_update_tb failed");
      $finish;
    end
  end

  initial begin
    sclru_pkg::out_rsp_t none;
    int                  phase;
    int                  n;
    none = '0;
    for (n = 0; n < sclru_pkg::SET_COUNT; n++) begin
      data_ages[n] = '0;
      inst_ages[n] = '0;
    end

    // Directed rows. Fresh sets have all counters at zero.
    add_row(sclru_pkg::FUNC_DATA, 0, 0, 1'b0, 1'b1, 24'hFFFFFF, 1'b0);
    add_row(sclru_pkg::FUNC_DATA, 0, 7, 1'b0, 1'b0, '0, 1'b0);
    add_row(sclru_pkg::FUNC_DATA, 0, 3, 1'b1, 1'b0, '0, 1'b0);
    add_row(sclru_pkg::FUNC_DATA, 0, 1, 1'b0, 1'b0, '0, 1'b0);
    add_row(sclru_pkg::FUNC_DATA, 0, 6, 1'b0, 1'b0, '0, 1'b0);
    add_row(sclru_pkg::FUNC_DATA, 0, 3, 1'b0, 1'b0, '0, 1'b0);
    add_row(sclru_pkg::FUNC_DATA, 16383, 0, 1'b1, 1'b1, 24'h000007, 1'b0);
    add_row(sclru_pkg::FUNC_DATA, 16383, 7, 1'b1, 1'b0, '0, 1'b0);
    add_row(sclru_pkg::FUNC_DATA, 16383, 7, 1'b0, 1'b0, '0, 1'b0);
    add_row(sclru_pkg::FUNC_DATA, 'h2AAA, 5, 1'b1, 1'b0, '0, 1'b0);
    add_row(sclru_pkg::FUNC_DATA, 'h1555, 2, 1'b0, 1'b0, '0, 1'b0);
    add_row(sclru_pkg::FUNC_INST, 0, 0, 1'b0, 1'b1, 24'h0000FF, 1'b0);
    add_row(sclru_pkg::FUNC_INST, 16383, 3, 1'b1, 1'b1, 24'h0000FF, 1'b0);
    add_row(sclru_pkg::FUNC_INST, 1, 0, 1'b1, 1'b1, 24'h000003, 1'b0);
    add_row(sclru_pkg::FUNC_INST, 5, 4, 1'b0, 1'b1, 24'h000000, 1'b1);
    add_row(sclru_pkg::FUNC_INST, 5, 7, 1'b1, 1'b1, 24'h000000, 1'b1);
    add_row(sclru_pkg::FUNC_INST, 0, 7, 1'b0, 1'b0, '0, 1'b0);
    add_row(sclru_pkg::FUNC_INST, 0, 2, 1'b0, 1'b0, '0, 1'b0);
    add_row(sclru_pkg::FUNC_INST, 0, 1, 1'b1, 1'b0, '0, 1'b0);
    add_row(sclru_pkg::FUNC_INST, 0, 3, 1'b0, 1'b0, '0, 1'b0);
    add_row(sclru_pkg::FUNC_INST, 0, 5, 1'b1, 1'b0, '0, 1'b0);
    add_row(sclru_pkg::FUNC_INST, 0, 0, 1'b0, 1'b0, '0, 1'b0);

    // Reset once; the block then clears its stores while stalling its input.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (access_table[k]) begin
      send_access(access_table[k].req, access_table[k].known, access_table[k].want);
    end

    // Random phases: sender idles less than receiver, then the reverse, then no idling.
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 83 : 0;
      recv_idle_pct = (phase == 0) ? 83 : (phase == 1) ? 24 : 0;
      if (phase == 2) begin
        // Hold the result channel off while requests keep coming.
        squeeze_asked++;
      end
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_access(make_random_access(), 1'b0, none);
      end
    end
    in_valid <= 1'b0;

    // Drain, then idle for DRAIN_CYCLES to catch any stray result.
    while (pending_counters.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("split_cache_lru_counter_update_tb passed");
    end else begin
      $display("split_cache_lru_counter_update_tb failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/sclru_pkg.sv
rtl/sclru_age_calc.sv
rtl/split_cache_lru_counter_update.sv
tb/sv/split_cache_lru_counter_update_tb.sv
